// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the line start search RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/lsis_pkg.sv =====
// Package with types and constants of the line start index search block.
package lsis_pkg;

   localparam int MAX_LINES_DEF   = 4096;
   localparam int OFFSET_BITS_DEF = 24;

   localparam int CMD_BITS        = 2;
   localparam int BYTE_BITS       = 8;
   localparam int OFFSET_W        = 24;
   localparam int LINE_INDEX_BITS = 12;
   localparam int LINE_TOTAL_BITS = 13;

   localparam logic [BYTE_BITS-1:0] NEWLINE_BYTE = 8'd10;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_BYTE  = 2'd1,
      CMD_PUSH  = 2'd2,
      CMD_FIND  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [CMD_BITS-1:0]  command;
      logic [BYTE_BITS-1:0] source_byte;
      logic [OFFSET_W-1:0]  byte_offset;
   } req_word_type;

   typedef struct packed {
      logic [LINE_INDEX_BITS-1:0] line_index;
      logic [LINE_TOTAL_BITS-1:0] line_total;
      logic                       overflowed;
   } rsp_word_type;

   // Status of the search engine as seen by the command logic.
   typedef struct packed {
      logic busy;
      logic done;
   } srch_stat_type;

endpackage

// ===== rtl/lsis_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module lsis_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/lsis_search.sv =====
// Halving search engine that probes the line start table one entry per cycle.
`include "assert_macros.svh"
module lsis_search import lsis_pkg::*; #(
   parameter int MAX_LINES   = MAX_LINES_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [OFFSET_BITS-1:0]       offset,
   input  logic [$clog2(MAX_LINES)-1:0] top_index,
   input  logic                         out_free,
   input  logic [OFFSET_BITS-1:0]       rd_data,
   output logic [$clog2(MAX_LINES)-1:0] rd_addr,
   output logic [$clog2(MAX_LINES)-1:0] result_index,
   output srch_stat_type                status
);

   localparam int ADDR_BITS = $clog2(MAX_LINES);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_PROBE = 2'b10
   } state_type;

   state_type              state_ff, state_in;
   logic [ADDR_BITS-1:0]   probe_ff, probe_in;
   logic [ADDR_BITS-1:0]   upper_ff, upper_in;
   logic [ADDR_BITS-1:0]   lower_ff, lower_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;

   logic [OFFSET_BITS-1:0] value;
   logic                   above;
   logic [ADDR_BITS:0]     sum_lo, sum_hi;
   logic [ADDR_BITS-1:0]   mid_lo, mid_hi, span;
   logic                   finish;
   logic [ADDR_BITS-1:0]   cand_probe, cand_upper, cand_lower;

   // Entry 0 is never written and always reads as zero.
   always_comb begin
      value  = (probe_ff == '0) ? '0 : rd_data;
      above  = value > offset_ff;
      sum_lo = {1'b0, probe_ff} + {1'b0, lower_ff};
      sum_hi = {1'b0, upper_ff} + {1'b0, probe_ff};
      mid_lo = sum_lo[ADDR_BITS:1];
      mid_hi = sum_hi[ADDR_BITS:1];
      span   = upper_ff - probe_ff;
   end

   // One probe step: narrow the window, or finish with the current probe or with entry 0.
   always_comb begin
      finish       = 1'b0;
      result_index = probe_ff;
      cand_probe   = probe_ff;
      cand_upper   = upper_ff;
      cand_lower   = lower_ff;
      if (above) begin
         cand_upper = probe_ff;
         if (mid_lo == '0) begin
            finish       = 1'b1;
            result_index = '0;
         end else begin
            cand_probe = mid_lo;
         end
      end else begin
         if (span <= ADDR_BITS'(1)) begin
            finish = 1'b1;
         end else begin
            cand_lower = probe_ff;
            cand_probe = mid_hi;
         end
      end
   end

   // Sequencer and read address; a finished search holds until the result slot frees.
   always_comb begin
      state_in    = state_ff;
      probe_in    = probe_ff;
      upper_in    = upper_ff;
      lower_in    = lower_ff;
      offset_in   = offset_ff;
      rd_addr     = top_index;
      status.busy = 1'b0;
      status.done = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in  = ST_PROBE;
               probe_in  = top_index;
               upper_in  = top_index;
               lower_in  = '0;
               offset_in = offset;
            end
         end
         ST_PROBE: begin
            status.busy = 1'b1;
            if (finish) begin
               rd_addr = probe_ff;
               if (out_free) begin
                  status.done = 1'b1;
                  state_in    = ST_IDLE;
               end
            end else begin
               probe_in = cand_probe;
               upper_in = cand_upper;
               lower_in = cand_lower;
               rd_addr  = cand_probe;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      probe_ff  <= probe_in;
      upper_ff  <= upper_in;
      lower_ff  <= lower_in;
      offset_ff <= offset_in;
   end

   `ASSERT_IMPLY(a_probe_in_window, clock, reset, state_ff == ST_PROBE,
                 lower_ff <= probe_ff && probe_ff <= upper_ff)
   `ASSERT_IMPLY(a_done_has_slot, clock, reset, status.done, out_free)

endmodule

// ===== rtl/line_start_index_search.sv =====
// Top level of the line start index search block.
// Keeps a table of line start offsets in one RAM. Clear, source byte and push
// commands finish in the cycle they are accepted, so they may stream every
// cycle while no find is in progress. A find command issues the read of the
// last entry when it is accepted and then probes one entry at a time, because
// the single RAM read port delivers one table entry per cycle. No further
// word is taken until the find has written its result into the output
// register; a result waiting there does not block other commands.
// Entry 0 is never stored and reads as zero, so the block needs no clearing
// pass after reset.
`include "assert_macros.svh"
module line_start_index_search import lsis_pkg::*; #(
   parameter int MAX_LINES   = MAX_LINES_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data
);

   localparam int ADDR_BITS = $clog2(MAX_LINES);
   localparam int CNT_BITS  = $clog2(MAX_LINES + 1);
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(MAX_LINES);

   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic                   ovf_ff, ovf_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_data_ff, rsp_data_in;

   logic                   accept, out_free, start;
   logic [OFFSET_BITS-1:0] offset, pos_next;
   logic [CNT_BITS-1:0]    top_count;
   logic [ADDR_BITS-1:0]   top_index, rd_addr, result_index;
   logic [OFFSET_BITS-1:0] rd_data;
   logic                   wr_en;
   logic [OFFSET_BITS-1:0] wr_data;
   srch_stat_type          status;

   assign accept    = req_valid && !req_stall;
   assign req_stall = status.busy;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign offset    = OFFSET_BITS'(req_data.byte_offset);
   assign pos_next  = pos_ff + OFFSET_BITS'(1);
   assign top_count = count_ff - CNT_BITS'(1);
   assign top_index = top_count[ADDR_BITS-1:0];

   // Command decode: clear, position, appends, overflow and search start.
   always_comb begin
      count_in = count_ff;
      pos_in   = pos_ff;
      ovf_in   = ovf_ff;
      wr_en    = 1'b0;
      wr_data  = offset;
      start    = 1'b0;
      if (accept) begin
         case (req_data.command)
            CMD_CLEAR: begin
               count_in = CNT_BITS'(1);
               pos_in   = '0;
               ovf_in   = 1'b0;
            end
            CMD_BYTE: begin
               pos_in  = pos_next;
               wr_data = pos_next;
               if (req_data.source_byte == NEWLINE_BYTE) begin
                  if (count_ff == FULL_COUNT) begin
                     ovf_in = 1'b1;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_BITS'(1);
                  end
               end
            end
            CMD_PUSH: begin
               if (count_ff == FULL_COUNT) begin
                  ovf_in = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_BITS'(1);
               end
            end
            CMD_FIND: begin
               start = 1'b1;
            end
            default: begin
               start = 1'b0;
            end
         endcase
      end
   end

   // Output register: loaded when a search finishes, emptied when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (status.done) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.line_index = LINE_INDEX_BITS'(result_index);
         rsp_data_in.line_total = LINE_TOTAL_BITS'(count_ff);
         rsp_data_in.overflowed = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= CNT_BITS'(1);
         pos_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   lsis_ram #(
      .WIDTH (OFFSET_BITS),
      .DEPTH (MAX_LINES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_BITS-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lsis_search #(
      .MAX_LINES   (MAX_LINES),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_search (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .offset       (offset),
      .top_index    (top_index),
      .out_free     (out_free),
      .rd_data      (rd_data),
      .rd_addr      (rd_addr),
      .result_index (result_index),
      .status       (status)
   );

   `ASSERT_IMPLY(a_count_range, clock, reset, 1'b1,
                 count_ff != '0 && count_ff <= FULL_COUNT)
   `ASSERT_IMPLY(a_no_write_in_search, clock, reset, wr_en, !status.busy)
   `ASSERT_IMPLY(a_overflow_only_full, clock, reset, $rose(ovf_ff),
                 $past(count_ff) == FULL_COUNT)

endmodule

// ===== verif/tb_line_start_index_search.sv =====
// Self-checking testbench for the line start index search block.
`timescale 1ns / 100ps
module tb_line_start_index_search import lsis_pkg::*; ();

   localparam int TABLE_DEPTH  = MAX_LINES_DEF;
   localparam int PROBE_LIMIT  = 128;
   localparam int DRAIN_CYCLES = 40;
   localparam int FILL_WORDS   = 64;
   localparam int RANDOM_WORDS = 430;
   localparam int PHASE_WORDS  = 96;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;

   // Words waiting to be sent, and line lookups waiting to come back.
   req_word_type pending_words[$];
   rsp_word_type expected_lines[$];

   // Shadow copy of the block's state.
   logic [OFFSET_W-1:0]        line_starts [TABLE_DEPTH] = '{default: '0};
   int unsigned                line_count = 1;
   logic [OFFSET_W-1:0]        scan_pos = '0;
   logic                       lines_dropped = 1'b0;

   int unsigned error_count = 0;
   int unsigned words_taken = 0;
   int unsigned words_queued = 0;
   logic        req_fire = 1'b0;

   line_start_index_search u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // Print one line per mismatch; printing stops after 200 mismatches, counting does not.
   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (error_count < 200) begin
         $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
      end
      error_count++;
   endtask

   task automatic queue_word(input cmd_type cmd, input logic [BYTE_BITS-1:0] b,
                             input logic [OFFSET_W-1:0] off);
      req_word_type w;
      w.command     = cmd;
      w.source_byte = b;
      w.byte_offset = off;
      pending_words = {pending_words, w};
      words_queued++;
   endtask

   // Append a line start unless the table is full.
   task automatic add_line_start(input logic [OFFSET_W-1:0] value);
      if (line_count >= TABLE_DEPTH) begin
         lines_dropped = 1'b1;
      end else begin
         line_starts[line_count] = value;
         line_count++;
      end
   endtask

   // Halving search with a fixed probe order, starting from the last entry.
   function automatic logic [LINE_INDEX_BITS-1:0] search_line(input logic [OFFSET_W-1:0] off);
      int unsigned probe;
      int unsigned upper;
      int unsigned lower;
      probe = line_count - 1;
      upper = probe;
      lower = 0;
      for (int n = 0; n < PROBE_LIMIT; n++) begin
         if (line_starts[probe] > off) begin
            upper = probe;
            probe = (upper + lower) / 2;
            if (probe == 0) return '0;
         end else begin
            if (upper - probe <= 1) return probe[LINE_INDEX_BITS-1:0];
            lower = probe;
            probe = (upper + lower) / 2;
         end
      end
      return probe[LINE_INDEX_BITS-1:0];
   endfunction

   // Update the shadow state for one accepted word and queue any lookup result.
   task automatic apply_word(input req_word_type w);
      rsp_word_type r;
      case (cmd_type'(w.command))
         CMD_CLEAR: begin
            line_starts[0] = '0;
            line_count     = 1;
            scan_pos       = '0;
            lines_dropped  = 1'b0;
         end
         CMD_BYTE: begin
            scan_pos = scan_pos + OFFSET_W'(1);
            if (w.source_byte == NEWLINE_BYTE) add_line_start(scan_pos);
         end
         CMD_PUSH: begin
            add_line_start(w.byte_offset);
         end
         CMD_FIND: begin
            r.line_index = search_line(w.byte_offset);
            r.line_total = line_count[LINE_TOTAL_BITS-1:0];
            r.overflowed = lines_dropped;
            expected_lines = {expected_lines, r};
         end
         default: begin
         end
      endcase
   endtask

   // Monitor: track accepted input words and check every accepted result.
   always @(posedge clock) begin : monitor
      rsp_word_type want;
      req_fire = !reset && req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_lines.size() == 0) begin
               report_mismatch("result with no lookup waiting",
                               32'(rsp_data.line_index), 0);
            end else begin
               want = expected_lines.pop_front();
               if (rsp_data.line_index != want.line_index)
                  report_mismatch("line_index", 32'(rsp_data.line_index),
                                  32'(want.line_index));
               if (rsp_data.line_total != want.line_total)
                  report_mismatch("line_total", 32'(rsp_data.line_total),
                                  32'(want.line_total));
               if (rsp_data.overflowed != want.overflowed)
                  report_mismatch("overflowed", 32'(rsp_data.overflowed),
                                  32'(want.overflowed));
            end
         end
         if (req_fire) begin
            apply_word(pending_words.pop_front());
            words_taken++;
         end
      end
   end

   // Driver: idling pattern rotates through four phases as words are taken.
   always @(negedge clock) begin : driver
      int unsigned send_pct;
      int unsigned recv_pct;
      case ((words_taken / PHASE_WORDS) % 4)
         0:       begin send_pct = 0;  recv_pct = 0;  end
         1:       begin send_pct = 54; recv_pct = 0;  end
         2:       begin send_pct = 0;  recv_pct = 54; end
         default: begin send_pct = 34; recv_pct = 34; end
      endcase
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_fire) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_words[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_pct);
      end
   end

   // Stimulus and end of run.
   initial begin : stimulus
      int unsigned text_pos;
      int unsigned last_start;
      int unsigned seg_len;
      int unsigned kind;
      int unsigned random_base;

      // Directed: empty table, text bytes, pushes out of order, clear.
      queue_word(CMD_FIND, 8'h00, 24'h000000);
      queue_word(CMD_FIND, 8'hFF, 24'hFFFFFF);
      queue_word(CMD_BYTE, 8'hFF, 24'hFFFFFF);
      queue_word(CMD_BYTE, 8'h00, 24'h000000);
      queue_word(CMD_BYTE, NEWLINE_BYTE, 24'h000000);
      queue_word(CMD_FIND, 8'h00, 24'h000002);
      queue_word(CMD_FIND, 8'h00, 24'h000003);
      queue_word(CMD_FIND, 8'h00, 24'h000004);
      queue_word(CMD_BYTE, NEWLINE_BYTE, 24'h000000);
      queue_word(CMD_FIND, 8'h00, 24'h000004);
      queue_word(CMD_PUSH, 8'h00, 24'hFFFFFF);
      queue_word(CMD_FIND, 8'h00, 24'hFFFFFF);
      queue_word(CMD_FIND, 8'h00, 24'hFFFFFE);
      queue_word(CMD_PUSH, 8'h00, 24'h800000);
      queue_word(CMD_PUSH, 8'h00, 24'h000001);
      queue_word(CMD_FIND, 8'h00, 24'h7FFFFF);
      queue_word(CMD_FIND, 8'h00, 24'hFFFFFF);
      queue_word(CMD_CLEAR, 8'h00, 24'h000000);
      queue_word(CMD_FIND, 8'h00, 24'h000005);
      queue_word(CMD_PUSH, 8'h00, 24'h000000);
      queue_word(CMD_FIND, 8'h00, 24'h000000);
      queue_word(CMD_CLEAR, 8'h00, 24'h000000);

      // Build a longer sorted table from pushed starts and search it.
      last_start = 0;
      for (int i = 0; i < FILL_WORDS; i++) begin
         last_start = last_start + $urandom_range(4000, 1);
         queue_word(CMD_PUSH, 8'h00, last_start[OFFSET_W-1:0]);
      end
      queue_word(CMD_BYTE, NEWLINE_BYTE, 24'h000000);
      queue_word(CMD_FIND, 8'h00, 24'h000000);
      queue_word(CMD_FIND, 8'h00, 24'hFFFFFF);
      for (int i = 0; i < 24; i++) begin
         queue_word(CMD_FIND, 8'h00, OFFSET_W'($urandom_range(last_start)));
      end
      queue_word(CMD_CLEAR, 8'h00, 24'h000000);
      queue_word(CMD_FIND, 8'h00, 24'h000010);

      // Random: mostly sorted tables built from text or pushes, some noise.
      random_base = words_queued;
      text_pos = 0;
      last_start = 0;
      while (words_queued - random_base < RANDOM_WORDS) begin
         kind = $urandom_range(9);
         seg_len = $urandom_range(40, 8);
         if (kind < 4) begin
            if ($urandom_range(1) == 0) begin
               queue_word(CMD_CLEAR, 8'h00, 24'h000000);
               text_pos = 0;
            end
            for (int i = 0; i < seg_len; i++) begin
               if ($urandom_range(3) == 0) begin
                  queue_word(CMD_FIND, 8'h00, OFFSET_W'($urandom_range(text_pos + 3)));
               end else if ($urandom_range(5) == 0) begin
                  queue_word(CMD_BYTE, NEWLINE_BYTE, OFFSET_W'($urandom()));
                  text_pos++;
               end else begin
                  queue_word(CMD_BYTE, BYTE_BITS'($urandom_range(255)),
                             OFFSET_W'($urandom()));
                  text_pos++;
               end
            end
         end else if (kind < 7) begin
            if ($urandom_range(1) == 0) begin
               queue_word(CMD_CLEAR, 8'h00, 24'h000000);
               last_start = 0;
            end
            for (int i = 0; i < seg_len; i++) begin
               if ($urandom_range(2) == 0) begin
                  queue_word(CMD_FIND, BYTE_BITS'($urandom_range(255)),
                             OFFSET_W'($urandom_range(last_start + 100)));
               end else begin
                  last_start = (last_start + $urandom_range(1 << $urandom_range(18), 1))
                               & 24'hFFFFFF;
                  queue_word(CMD_PUSH, BYTE_BITS'($urandom_range(255)),
                             last_start[OFFSET_W-1:0]);
               end
            end
         end else begin
            for (int i = 0; i < seg_len / 2; i++) begin
               queue_word(cmd_type'(CMD_BITS'($urandom_range(3))),
                          BYTE_BITS'($urandom_range(255)), OFFSET_W'($urandom()));
            end
         end
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0) @(negedge clock);
      while (expected_lines.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("tb_line_start_index_search: clean");
      end else begin
         $display("tb_line_start_index_search: errors");
      end
      $finish;
   end

   // Timeout well beyond the slowest correct run.
   initial begin : watchdog
      #2000000;
      $display("tb_line_start_index_search: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lsis_pkg.sv
rtl/lsis_ram.sv
rtl/lsis_search.sv
rtl/line_start_index_search.sv
verif/tb_line_start_index_search.sv
